// ===== hdl/vcpc_pkg.sv =====
`timescale 1ns / 1ps
package vcpc_pkg;

	// datapath widths, all geometry in units of 2^-17
	localparam int CW   = 34;          // x/z difference, signed
	localparam int YW   = 36;          // segment ends on y, signed
	localparam int MW   = 36;          // component magnitude
	localparam int HW   = MW / 2;      // half of a magnitude for the square split
	localparam int RSW  = 33;          // doubled radius sum
	localparam int SQ_N = 37;          // root bits, one per stage
	localparam int TW   = 2 * SQ_N + 2;
	localparam int DIV_N = 17;         // quotient bits, one per stage
	localparam int DW   = 54;          // divider remainder
	localparam int DEPTH_MIN = 131;    // 0.001 in units of 2^-17, rounded down
	localparam int LAT  = 7 + SQ_N + 1 + DIV_N + 1;

	typedef struct packed {
		logic [7:0]     mat;
		logic [RSW-1:0] rs;
		logic           sx;
		logic           sy;
		logic           sz;
		logic [MW-1:0]  mx;
		logic [MW-1:0]  my;
		logic [MW-1:0]  mz;
	} geo_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] dep;
		logic [7:0]  mat;
		logic        sx;
		logic        sy;
		logic        sz;
		logic        lenz;
	} res_t;

endpackage

// ===== hdl/vertical_capsule_pair_collision.sv =====
`timescale 1ns / 1ps
// Vertical capsule pair collision, fully pipelined.
//
// Request channel: drive the two capsules and material_id with start high.
// busy is held low, so a request is taken at every edge where start is high;
// a new pair may follow in each cycle.
// Result channel: strobe is high for one cycle with hit, normal_x/y/z, depth
// and material_out. The receiver cannot hold results off; none is needed,
// as the pipeline never stops.
// Throughput: one pair per cycle. The depth is set by the square root, one
// root bit per stage (37 stages), and the normal division, one quotient bit
// per stage (17 stages, three lanes side by side).
// Front stages: segment ends, end choice, two clamps, split squares, sum.
// Reset clears every valid bit; results in flight are dropped and no strobe
// appears until new requests have passed through.
module vertical_capsule_pair_collision (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  a_center_x,
	input  logic signed [31:0]  a_center_y,
	input  logic signed [31:0]  a_center_z,
	input  logic [30:0]         a_radius,
	input  logic [30:0]         a_height,
	input  logic signed [31:0]  b_center_x,
	input  logic signed [31:0]  b_center_y,
	input  logic signed [31:0]  b_center_z,
	input  logic [30:0]         b_radius,
	input  logic [30:0]         b_height,
	input  logic [7:0]          material_id,
	output logic                strobe,
	output logic                hit,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic signed [15:0]  normal_z,
	output logic [31:0]         depth,
	output logic [7:0]          material_out
);

	localparam int YW  = vcpc_pkg::YW;
	localparam int CW  = vcpc_pkg::CW;
	localparam int MW  = vcpc_pkg::MW;
	localparam int HW  = vcpc_pkg::HW;
	localparam int TW  = vcpc_pkg::TW;
	localparam int SQN = vcpc_pkg::SQ_N;
	localparam int DVN = vcpc_pkg::DIV_N;
	localparam int DW  = vcpc_pkg::DW;

	function automatic logic [YW:0] abs_d(input logic signed [YW:0] v);
		abs_d = v[YW] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [YW-1:0] clamp_y(input logic signed [YW-1:0] v,
			input logic signed [YW-1:0] p, input logic signed [YW-1:0] q);
		logic signed [YW-1:0] lo;
		logic signed [YW-1:0] hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		clamp_y = (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [15:0] norm_q15(input logic [DVN-1:0] q, input logic neg,
			input logic lenz);
		logic [DVN-1:0] nq;
		nq = ~q + 1'b1;
		if (lenz)
			norm_q15 = 16'h0000;
		else if (neg)
			norm_q15 = (q > DVN'(32768)) ? 16'h8000 : nq[15:0];
		else
			norm_q15 = (q > DVN'(32767)) ? 16'h7FFF : q[15:0];
	endfunction

	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// ---------------- stage 1: doubled coordinates, segment ends ----------
	logic signed [CW-1:0] dx_c, dz_c;
	logic signed [YW-1:0] a0_c, a1_c, b0_c, b1_c;
	logic [vcpc_pkg::RSW-1:0] rs_c;

	always_comb begin
		dx_c = $signed({a_center_x[31], a_center_x, 1'b0})
			- $signed({b_center_x[31], b_center_x, 1'b0});
		dz_c = $signed({a_center_z[31], a_center_z, 1'b0})
			- $signed({b_center_z[31], b_center_z, 1'b0});
		a0_c = $signed({{3{a_center_y[31]}}, a_center_y, 1'b0}) - $signed({5'b0, a_height})
			+ $signed({4'b0, a_radius, 1'b0});
		a1_c = $signed({{3{a_center_y[31]}}, a_center_y, 1'b0}) + $signed({5'b0, a_height})
			- $signed({4'b0, a_radius, 1'b0});
		b0_c = $signed({{3{b_center_y[31]}}, b_center_y, 1'b0}) - $signed({5'b0, b_height})
			+ $signed({4'b0, b_radius, 1'b0});
		b1_c = $signed({{3{b_center_y[31]}}, b_center_y, 1'b0}) + $signed({5'b0, b_height})
			- $signed({4'b0, b_radius, 1'b0});
		rs_c = {1'b0, a_radius, 1'b0} + {1'b0, b_radius, 1'b0};
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [CW-1:0] dx_s1, dz_s1, dx_s2, dz_s2, dx_s3, dz_s3;
	logic signed [YW-1:0] a0_s1, a1_s1, b0_s1, b1_s1;
	logic signed [YW-1:0] a0_s2, a1_s2, b0_s2, b1_s2, besta_s2;
	logic signed [YW-1:0] a0_s3, a1_s3, pb_s3;
	logic [vcpc_pkg::RSW-1:0] rs_s1, rs_s2, rs_s3;
	logic [7:0] mat_s1, mat_s2, mat_s3;

	always_ff @(posedge clk) begin
		dx_s1  <= dx_c;
		dz_s1  <= dz_c;
		a0_s1  <= a0_c;
		a1_s1  <= a1_c;
		b0_s1  <= b0_c;
		b1_s1  <= b1_c;
		rs_s1  <= rs_c;
		mat_s1 <= material_id;
	end

	// ---------------- stage 2: end choice on |dy| alone -------------------
	logic [YW:0] e0, e1, e2, e3;
	logic signed [YW-1:0] besta_c;

	always_comb begin
		e0 = abs_d($signed({b0_s1[YW-1], b0_s1}) - $signed({a0_s1[YW-1], a0_s1}));
		e1 = abs_d($signed({b1_s1[YW-1], b1_s1}) - $signed({a0_s1[YW-1], a0_s1}));
		e2 = abs_d($signed({b0_s1[YW-1], b0_s1}) - $signed({a1_s1[YW-1], a1_s1}));
		e3 = abs_d($signed({b1_s1[YW-1], b1_s1}) - $signed({a1_s1[YW-1], a1_s1}));
		besta_c = (e2 < e0 || e2 < e1 || e3 < e0 || e3 < e1) ? a1_s1 : a0_s1;
	end

	always_ff @(posedge clk) begin
		besta_s2 <= besta_c;
		a0_s2    <= a0_s1;
		a1_s2    <= a1_s1;
		b0_s2    <= b0_s1;
		b1_s2    <= b1_s1;
		dx_s2    <= dx_s1;
		dz_s2    <= dz_s1;
		rs_s2    <= rs_s1;
		mat_s2   <= mat_s1;
	end

	// ---------------- stage 3: closest point on second segment -----------
	always_ff @(posedge clk) begin
		pb_s3  <= clamp_y(besta_s2, b0_s2, b1_s2);
		a0_s3  <= a0_s2;
		a1_s3  <= a1_s2;
		dx_s3  <= dx_s2;
		dz_s3  <= dz_s2;
		rs_s3  <= rs_s2;
		mat_s3 <= mat_s2;
	end

	// ---------------- stage 4: closest point on first, magnitudes ---------
	logic signed [YW-1:0] pa_c;
	logic signed [YW:0]   dy_c;
	logic [YW:0]          ax_m, ay_m, az_m;
	vcpc_pkg::geo_t       g_s4, g_s5, g_s6, g_s7;

	always_comb begin
		pa_c = clamp_y(pb_s3, a0_s3, a1_s3);
		dy_c = $signed({pa_c[YW-1], pa_c}) - $signed({pb_s3[YW-1], pb_s3});
		ax_m = abs_d($signed({{(YW+1-CW){dx_s3[CW-1]}}, dx_s3}));
		ay_m = abs_d(dy_c);
		az_m = abs_d($signed({{(YW+1-CW){dz_s3[CW-1]}}, dz_s3}));
	end

	always_ff @(posedge clk) begin
		g_s4.mat <= mat_s3;
		g_s4.rs  <= rs_s3;
		g_s4.sx  <= dx_s3[CW-1];
		g_s4.sy  <= dy_c[YW];
		g_s4.sz  <= dz_s3[CW-1];
		g_s4.mx  <= ax_m[MW-1:0];
		g_s4.my  <= ay_m[MW-1:0];
		g_s4.mz  <= az_m[MW-1:0];
	end

	// ---------------- stage 5: 18x18 partial products ---------------------
	logic [MW-1:0] hh_s5 [3];
	logic [MW-1:0] hl_s5 [3];
	logic [MW-1:0] ll_s5 [3];
	logic [MW-1:0] mag_c [3];

	always_comb begin
		mag_c[0] = g_s4.mx;
		mag_c[1] = g_s4.my;
		mag_c[2] = g_s4.mz;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s5[i] <= mag_c[i][MW-1:HW] * mag_c[i][MW-1:HW];
			hl_s5[i] <= mag_c[i][MW-1:HW] * mag_c[i][HW-1:0];
			ll_s5[i] <= mag_c[i][HW-1:0]  * mag_c[i][HW-1:0];
		end
		g_s5 <= g_s4;
	end

	// ---------------- stage 6: squares; stage 7: sum ----------------------
	logic [TW-1:0] sq_s6 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s6[i] <= ({{(TW-MW){1'b0}}, hh_s5[i]} << (2 * HW))
				+ ({{(TW-MW){1'b0}}, hl_s5[i]} << (HW + 1))
				+ {{(TW-MW){1'b0}}, ll_s5[i]};
		g_s6 <= g_s5;
	end

	// square root pipe: remainder, partial root, carried geometry
	logic [TW-1:0]  sq_r_s [SQN+1];
	logic [SQN-1:0] sq_q_s [SQN+1];
	vcpc_pkg::geo_t sq_g_s [SQN+1];
	logic           sq_v_s [SQN+1];

	always_ff @(posedge clk) begin
		g_s7 <= g_s6;
	end

	assign sq_r_s[0] = '0;
	always_ff @(posedge clk) begin
		sq_q_s[0] <= '0;
	end

	// sum lands directly in the first root stage's remainder
	logic [TW-1:0] ssum_s7;
	always_ff @(posedge clk) begin
		ssum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
	end

	assign sq_g_s[0] = g_s7;
	assign sq_v_s[0] = v_s7;

	// ---------------- digit-by-digit square root -------------------------
	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		localparam int I = SQN - 1 - k;
		logic [TW-1:0] rin;
		logic [TW-1:0] trial;
		always_comb begin
			rin   = (k == 0) ? ssum_s7 : sq_r_s[k];
			trial = ({{(TW-SQN){1'b0}}, sq_q_s[k]} << (I + 1))
				+ ({{(TW-1){1'b0}}, 1'b1} << (2 * I));
		end
		always_ff @(posedge clk) begin
			if (rin >= trial) begin
				sq_r_s[k+1] <= rin - trial;
				sq_q_s[k+1] <= sq_q_s[k] | ({{(SQN-1){1'b0}}, 1'b1} << I);
			end else begin
				sq_r_s[k+1] <= rin;
				sq_q_s[k+1] <= sq_q_s[k];
			end
			sq_g_s[k+1] <= sq_g_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k+1] <= 1'b0;
			else
				sq_v_s[k+1] <= sq_v_s[k];
		end
	end

	// ---------------- hit test, depth, dividends -------------------------
	logic [SQN-1:0]      len_c;
	logic signed [SQN:0] d_c;
	vcpc_pkg::geo_t      gl_c;

	always_comb begin
		len_c = sq_q_s[SQN];
		gl_c  = sq_g_s[SQN];
		d_c   = $signed({{(SQN+1-vcpc_pkg::RSW){1'b0}}, gl_c.rs})
			- $signed({1'b0, len_c});
	end

	logic [DW-1:0]      dv_r_s [DVN+1][3];
	logic [DVN-1:0]     dv_q_s [DVN+1][3];
	logic [SQN-1:0]     dv_l_s [DVN+1];
	vcpc_pkg::res_t     dv_c_s [DVN+1];
	logic               dv_v_s [DVN+1];
	logic [MW-1:0]      gm_c [3];

	always_comb begin
		gm_c[0] = gl_c.mx;
		gm_c[1] = gl_c.my;
		gm_c[2] = gl_c.mz;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_r_s[0][i] <= ({{(DW-MW){1'b0}}, gm_c[i]} << 15)
				+ {{(DW-SQN){1'b0}}, len_c >> 1};
			dv_q_s[0][i] <= '0;
		end
		dv_l_s[0]      <= len_c;
		dv_c_s[0].hit  <= d_c > $signed((SQN+1)'(vcpc_pkg::DEPTH_MIN));
		dv_c_s[0].dep  <= (d_c[SQN-1:33] != '0) ? 32'hFFFF_FFFF : d_c[32:1];
		dv_c_s[0].mat  <= gl_c.mat;
		dv_c_s[0].sx   <= gl_c.sx;
		dv_c_s[0].sy   <= gl_c.sy;
		dv_c_s[0].sz   <= gl_c.sz;
		dv_c_s[0].lenz <= (len_c == '0);
	end

	// ---------------- restoring division, three lanes --------------------
	for (genvar k = 0; k < DVN; k++) begin : g_div
		localparam int J = DVN - 1 - k;
		logic [DW-1:0] dvs;
		always_comb dvs = {{(DW-SQN){1'b0}}, dv_l_s[k]} << J;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_r_s[k][i] >= dvs) begin
					dv_r_s[k+1][i] <= dv_r_s[k][i] - dvs;
					dv_q_s[k+1][i] <= dv_q_s[k][i] | ({{(DVN-1){1'b0}}, 1'b1} << J);
				end else begin
					dv_r_s[k+1][i] <= dv_r_s[k][i];
					dv_q_s[k+1][i] <= dv_q_s[k][i];
				end
			end
			dv_l_s[k+1] <= dv_l_s[k];
			dv_c_s[k+1] <= dv_c_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k+1] <= 1'b0;
			else
				dv_v_s[k+1] <= dv_v_s[k];
		end
	end

	// front valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else begin
			v_s1      <= take;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			dv_v_s[0] <= sq_v_s[SQN];
		end
	end

	// ---------------- result register ------------------------------------
	vcpc_pkg::res_t rf_c;
	logic strobe_q, hit_q;
	logic [15:0] nx_q, ny_q, nz_q;
	logic [31:0] depth_q;
	logic [7:0]  mat_q;

	assign rf_c = dv_c_s[DVN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= dv_v_s[DVN];
	end

	always_ff @(posedge clk) begin
		hit_q   <= rf_c.hit;
		nx_q    <= rf_c.hit ? norm_q15(dv_q_s[DVN][0], rf_c.sx, rf_c.lenz) : 16'h0000;
		ny_q    <= rf_c.hit ? norm_q15(dv_q_s[DVN][1], rf_c.sy, rf_c.lenz) : 16'h0000;
		nz_q    <= rf_c.hit ? norm_q15(dv_q_s[DVN][2], rf_c.sz, rf_c.lenz) : 16'h0000;
		depth_q <= rf_c.hit ? rf_c.dep : 32'h0;
		mat_q   <= rf_c.hit ? rf_c.mat : 8'h00;
	end

	assign strobe       = strobe_q;
	assign hit          = hit_q;
	assign normal_x     = $signed(nx_q);
	assign normal_y     = $signed(ny_q);
	assign normal_z     = $signed(nz_q);
	assign depth        = depth_q;
	assign material_out = mat_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##(vcpc_pkg::LAT) strobe)
		else $error("request lost in pipeline");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(take, vcpc_pkg::LAT))
		else $error("result without request");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !hit) |-> (normal_x == 16'sd0 && normal_y == 16'sd0
			&& normal_z == 16'sd0 && depth == 32'd0 && material_out == 8'd0))
		else $error("miss with non-zero payload");
	a_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && hit) |-> (depth > 32'd65))
		else $error("hit below threshold");
`endif

endmodule

// ===== tb/vcpc_checker.sv =====
`timescale 1ns / 1ps
module vcpc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] a_center_x,
	input  logic signed [31:0] a_center_y,
	input  logic signed [31:0] a_center_z,
	input  logic [30:0]        a_radius,
	input  logic [30:0]        a_height,
	input  logic signed [31:0] b_center_x,
	input  logic signed [31:0] b_center_y,
	input  logic signed [31:0] b_center_z,
	input  logic [30:0]        b_radius,
	input  logic [30:0]        b_height,
	input  logic [7:0]         material_id,
	input  logic               strobe,
	input  logic               hit,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [31:0]        depth,
	input  logic [7:0]         material_out,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic        hit;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [31:0] dep;
		logic [7:0]  mat;
	} contact_t;

	contact_t contact_q[$];

	function automatic longint clamp_y(longint v, longint p, longint q);
		longint lo, hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint absl(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// floor square root, bit by bit, for values below 2^76
	function automatic logic [63:0] root128(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = 37; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_q15(longint c, logic [63:0] len);
		logic [127:0] q;
		if (len == 0)
			return 16'd0;
		q = ({64'd0, absl(c)} * 128'd32768 + (len >> 1)) / len;
		if (c < 0)
			return (q > 32768) ? 16'h8000 : 16'(-q);
		return (q > 32767) ? 16'h7fff : 16'(q);
	endfunction

	function automatic contact_t predict_contact();
		longint ax, ay, az, ar, ah, bx, by, bz, br, bh;
		longint a0, a1, b0, b1, e0, e1, e2, e3, besta, pb, pa, dx, dy, dz, d;
		logic [127:0] sq;
		logic [63:0] len, dp;
		contact_t c;
		ax = 2 * longint'(a_center_x); ay = 2 * longint'(a_center_y);
		az = 2 * longint'(a_center_z);
		bx = 2 * longint'(b_center_x); by = 2 * longint'(b_center_y);
		bz = 2 * longint'(b_center_z);
		ar = longint'(a_radius); ah = longint'(a_height);
		br = longint'(b_radius); bh = longint'(b_height);
		a0 = ay - ah + 2 * ar; a1 = ay + ah - 2 * ar;
		b0 = by - bh + 2 * br; b1 = by + bh - 2 * br;
		e0 = absl(b0 - a0); e1 = absl(b1 - a0);
		e2 = absl(b0 - a1); e3 = absl(b1 - a1);
		besta = (e2 < e0 || e2 < e1 || e3 < e0 || e3 < e1) ? a1 : a0;
		pb = clamp_y(besta, b0, b1);
		pa = clamp_y(pb, a0, a1);
		dx = ax - bx; dy = pa - pb; dz = az - bz;
		sq = {64'd0, absl(dx)} * {64'd0, absl(dx)} + {64'd0, absl(dy)} * {64'd0, absl(dy)}
			+ {64'd0, absl(dz)} * {64'd0, absl(dz)};
		len = root128(sq);
		d = 2 * (ar + br) - longint'(len);
		c = '0;
		if (d > 131) begin
			dp = 64'(d) >> 1;
			c.hit = 1'b1;
			c.nx = unit_q15(dx, len);
			c.ny = unit_q15(dy, len);
			c.nz = unit_q15(dz, len);
			c.dep = (dp > 64'hffffffff) ? 32'hffffffff : dp[31:0];
			c.mat = material_id;
		end
		return c;
	endfunction

	initial fail_count = 0;
	assign pending = contact_q.size();

	always @(posedge clk) begin
		contact_t exp_c, got;
		if (arst_n) begin
			if (strobe) begin
				got = '{hit, normal_x, normal_y, normal_z, depth, material_out};
				if (contact_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					exp_c = contact_q.pop_front();
					if (got !== exp_c) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp hit=%b n=%h,%h,%h dep=%h mat=%h",
								" / got hit=%b n=%h,%h,%h dep=%h mat=%h"},
								exp_c.hit, exp_c.nx, exp_c.ny, exp_c.nz, exp_c.dep, exp_c.mat,
								got.hit, got.nx, got.ny, got.nz, got.dep, got.mat);
					end
				end
			end
			if (start && !busy)
				contact_q.push_back(predict_contact());
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	logic               clk, arst_n, start, busy, strobe, hit;
	logic signed [31:0] a_center_x, a_center_y, a_center_z;
	logic signed [31:0] b_center_x, b_center_y, b_center_z;
	logic [30:0]        a_radius, a_height, b_radius, b_height;
	logic [7:0]         material_id, material_out;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [31:0]        depth;
	int                 fail_count, pending;
	int                 idle_cycles;   // watchdog: cycles with nothing taken and no result

	localparam int WATCHDOG = 2000;

	vertical_capsule_pair_collision dut (.*);
	vcpc_checker chk (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// watchdog on accepted requests and results
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// load one request onto the ports
	task automatic drive_pair(logic [31:0] ax, ay, az, logic [30:0] ar, ah,
			logic [31:0] bx, by, bz, logic [30:0] br, bh, logic [7:0] m);
		a_center_x = ax; a_center_y = ay; a_center_z = az;
		a_radius = ar; a_height = ah;
		b_center_x = bx; b_center_y = by; b_center_z = bz;
		b_radius = br; b_height = bh;
		material_id = m;
	endtask

	// present the request at the falling edge, hold until taken
	task automatic send_request();
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 11)) @(negedge clk);
	endtask

	// random, mostly near-contact pairs so the hit path is well exercised
	task automatic random_pair(bit calm);
		logic [31:0] base;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			drive_pair($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom | 1),
				$urandom, $urandom, $urandom, 31'($urandom), 31'($urandom | 1),
				8'($urandom));
		end else if (sel < 3) begin
			// big radii, deep overlap, depth saturation region
			drive_pair($urandom, $urandom, $urandom, 31'(31'h40000000 | $urandom),
				31'($urandom | 1),
				$urandom, $urandom, $urandom, 31'(31'h40000000 | $urandom),
				31'($urandom | 1), 8'($urandom));
		end else begin
			base = $urandom;
			drive_pair(base + ($urandom_range(0, 2 ** 20) - 2 ** 19),
				base + ($urandom_range(0, 2 ** 22) - 2 ** 21),
				base + ($urandom_range(0, 2 ** 20) - 2 ** 19),
				31'($urandom_range(0, 2 ** 19)), 31'($urandom_range(1, 2 ** 22)),
				base + ($urandom_range(0, 2 ** 20) - 2 ** 19),
				base + ($urandom_range(0, 2 ** 22) - 2 ** 21),
				base + ($urandom_range(0, 2 ** 20) - 2 ** 19),
				31'($urandom_range(0, 2 ** 19)), 31'($urandom_range(1, 2 ** 22)),
				8'($urandom));
		end
		if (!calm && $urandom_range(0, 5) == 0)
			idle_burst();
		send_request();
	endtask

	initial begin
		int settle;
		start = 1'b0;
		idle_cycles = 0;
		drive_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: coincident centres give zero distance, zero normal
		drive_pair(0, 0, 0, 31'h10000, 31'h40000, 0, 0, 0, 31'h10000, 31'h40000, 8'hff);
		send_request();
		// touching and just overlapping: below the threshold, then two just above it
		drive_pair(0, 0, 0, 31'h10000, 31'h40000, 32'h20000, 0, 0, 31'h10000, 31'h40000, 1);
		send_request();
		drive_pair(0, 0, 0, 31'h10000, 31'h40000, 32'h1ffbe, 0, 0, 31'h10000, 31'h40000, 2);
		send_request();
		drive_pair(0, 0, 0, 31'h10000, 31'h40000, 32'h1ffbd, 0, 0, 31'h10000, 31'h40000, 3);
		send_request();
		// radius above half height: segment ends swapped
		drive_pair(0, 0, 0, 31'h40000, 31'h10000, 32'h8000, 32'h8000, 0,
			31'h30000, 31'h20000, 4);
		send_request();
		// zero-length segments on both capsules
		drive_pair(5, 7, 9, 31'h10000, 31'h20000, 0, 32'h10000, 0, 31'h8000, 31'h10000, 5);
		send_request();
		// vertical stack, a above and below b: apart along y, both misses
		drive_pair(0, 32'h50000, 0, 31'h10000, 31'h40000, 0, 0, 0, 31'h10000, 31'h40000, 6);
		send_request();
		drive_pair(0, 32'hfffb0000, 0, 31'h10000, 31'h40000, 0, 0, 0, 31'h10000, 31'h40000, 7);
		send_request();
		// extremes of every field
		drive_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff, 8'haa);
		send_request();
		drive_pair(32'h80000000, 32'h80000000, 32'h80000000, 0, 1,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1, 8'h55);
		send_request();
		drive_pair(32'h7fffffff, 0, 32'h80000000, 31'h7fffffff, 1,
			32'h7fffffff, 0, 32'h80000000, 31'h7fffffff, 1, 8'h0f);
		send_request();
		drive_pair(0, 32'h80000000, 0, 31'h7fffffff, 31'h7fffffff,
			0, 32'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff, 8'hf0);
		send_request();
		drive_pair(-32'sd1, -32'sd1, -32'sd1, 1, 1, 0, 0, 0, 1, 1, 8'h81);
		send_request();

		for (int i = 0; i < 1300; i++)
			random_pair(1'b0);
		// last part: back to back, no gaps
		for (int i = 0; i < 300; i++)
			random_pair(1'b1);
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		settle = 0;
		while (settle < 70) begin
			@(negedge clk);
			settle++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/vcpc_pkg.sv
hdl/vertical_capsule_pair_collision.sv
tb/vcpc_checker.sv
tb/tb.sv
